### rtl/core/llsp_pkg.sv
// Shared constants, types and the angle folding function for the globe
// point projection pipeline. No dependencies.
package llsp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VIEW_LON    = 3'd0,
    REG_VIEW_LAT    = 3'd1,
    REG_CAM_OFFSET  = 3'd2,
    REG_DISP_WIDTH  = 3'd3,
    REG_DISP_HEIGHT = 3'd4,
    REG_FOV_SCALE   = 3'd5
  } cfg_reg_t;

  // Angles in 1/64 degree, 18 bits covers any difference of two 15-bit angles.
  localparam int ANG_W = 18;
  localparam logic signed [ANG_W-1:0] TURN         = 18'sd23040;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 18'sd11520;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd5760;

  // CORDIC angle accumulator in 2^-22 degree.
  localparam int ZW = 31;
  localparam int ATAN_N = 24;
  localparam logic [ZW-1:0] ATAN_TABLE [0:ATAN_N-1] = '{
    31'd188743680, 31'd111421900, 31'd58872272, 31'd29884485, 31'd15000234,
    31'd7507429, 31'd3754631, 31'd1877430, 31'd938729, 31'd469366,
    31'd234683, 31'd117342, 31'd58671, 31'd29335, 31'd14668, 31'd7334,
    31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229, 31'd115, 31'd57, 31'd29
  };
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  // Quotient bits of the projection divide; larger magnitudes saturate.
  localparam int PROJ_QBITS = 21;

  localparam int OUT_W = 20;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;

  typedef struct packed {
    logic                neg;
    logic signed [13:0]  angle;
  } fold_t;

  // Reduce modulo a turn, then fold into +-90 degrees with a sign flip.
  function automatic fold_t fold_angle(logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    fold_t f;
    r = a;
    if (r >= TURN) begin
      r = r - TURN;
    end else if (r <= -TURN) begin
      r = r + TURN;
    end
    if (r > HALF_TURN) begin
      r = r - TURN;
    end else if (r < -HALF_TURN) begin
      r = r + TURN;
    end
    f.neg = 1'b0;
    if (r > QUARTER_TURN) begin
      r = r - HALF_TURN;
      f.neg = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r = r + HALF_TURN;
      f.neg = 1'b1;
    end
    f.angle = r[13:0];
    return f;
  endfunction

endpackage

### rtl/core/lat_lon_to_screen_projection.sv
// Globe point projection: CORDIC trig, view tilt, limb clamp with square
// root and renormalizing divide, projection divide and saturation.
// Depends on llsp_pkg.
//
// Throughput: one request per cycle while the result is not stalled; every
// loop (CORDIC, square root, both divides) is unrolled one step a stage.
// A stalled result freezes the whole pipeline, nothing is dropped.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults; no clearing pass.
module lat_lon_to_screen_projection
  import llsp_pkg::*;
#(
  parameter int TRIG_ITERATIONS = 16,
  parameter int FRACTION_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // point requests
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic signed [14:0]            point_longitude,
  input  logic signed [13:0]            point_latitude,
  // screen results
  output logic                          screen_valid,
  input  logic                          screen_stall,
  output logic signed [OUT_W-1:0]       screen_x,
  output logic signed [OUT_W-1:0]       screen_y,
  output logic                          limb_clamped,
  output logic                          saturated
);

  localparam int FB   = FRACTION_BITS;
  localparam int N    = TRIG_ITERATIONS;
  localparam int W_V  = FB + 3;               // unit vector component
  localparam int W_S  = 2 * W_V;              // squared length
  localparam int R_SQ = W_V;                  // square root result bits
  localparam int QR   = FB + 1;               // renormalize quotient bits
  localparam int W_RD = W_V + FB + 1;         // renormalize remainder
  localparam int W_ZD = FB + 10;              // depth
  localparam int W_DV = W_ZD + 7;             // depth * 256 magnitude
  localparam int W_HF = 29;                   // height * fov_scale
  localparam int W_N  = W_V + W_HF + 1;       // projection numerator
  localparam int QB   = PROJ_QBITS;
  localparam int W_PR = ((W_N > W_DV + QB) ? W_N : W_DV + QB) + 1;
  localparam int W_Q  = QB + 2;               // signed quotient plus center

  localparam longint GAIN = CORDIC_GAIN_Q30 >>> (30 - FB);
  localparam logic signed [W_V-1:0] GAIN_V  = W_V'(GAIN);
  localparam logic signed [W_V-1:0] LIMIT_V = W_V'(((1 << FB) + 5) / 10);

  typedef struct packed {
    logic signed [W_V-1:0] px;
    logic signed [W_V-1:0] py;
    logic signed [W_V-1:0] pz;
    logic                  clamp;
  } vec_t;

  typedef struct packed {
    logic       clamp;
    logic       den_ok;
    logic [1:0] neg;
    logic [1:0] ovf;
  } proj_ctl_t;

  // ---------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the result register
  // holds an item that the receiver stalls.
  // ---------------------------------------------------------------------
  logic adv;
  assign adv         = !(screen_valid && screen_stall);
  assign point_stall = !adv;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [14:0] view_longitude;
  logic signed [13:0] view_latitude;
  logic signed [16:0] camera_offset;
  logic [12:0]        display_width;
  logic [12:0]        display_height;
  logic [15:0]        fov_scale;
  logic [W_HF-1:0]    hf;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_longitude <= 15'sd0;
      view_latitude  <= 14'sd0;
      camera_offset  <= -17'sd768;
      display_width  <= 13'd320;
      display_height <= 13'd240;
      fov_scale      <= 16'd4096;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VIEW_LON:    view_longitude <= cfg_data[14:0];
        REG_VIEW_LAT:    view_latitude  <= cfg_data[13:0];
        REG_CAM_OFFSET:  camera_offset  <= cfg_data[16:0];
        REG_DISP_WIDTH:  display_width  <= cfg_data[12:0];
        REG_DISP_HEIGHT: display_height <= cfg_data[12:0];
        REG_FOV_SCALE:   fov_scale      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Scale factor register; changing it only while idle is up to the user.
  always_ff @(posedge clk) begin
    hf <= display_height * fov_scale;
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture the three angles (lane 0 longitude difference,
  // lane 1 point latitude, lane 2 negated view latitude)
  // ---------------------------------------------------------------------
  logic                    s0_valid;
  logic signed [ANG_W-1:0] s0_ang [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ang[0] <= {{3{view_longitude[14]}}, view_longitude}
                 - {{3{point_longitude[14]}}, point_longitude};
      s0_ang[1] <= {{4{point_latitude[13]}}, point_latitude};
      s0_ang[2] <= {ANG_W{1'b0}} - {{4{view_latitude[13]}}, view_latitude};
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC: fold into +-90 degrees, then one rotation per stage
  // ---------------------------------------------------------------------
  logic                  cv   [0:N];
  logic signed [W_V-1:0] cx   [0:N][0:2];
  logic signed [W_V-1:0] cy   [0:N][0:2];
  logic signed [ZW-1:0]  cz   [0:N][0:2];
  logic                  cneg [0:N][0:2];
  fold_t                 fa   [0:2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      fa[l] = fold_angle(s0_ang[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        cx[0][l]   <= GAIN_V;
        cy[0][l]   <= '0;
        cz[0][l]   <= {fa[l].angle[13], fa[l].angle, 16'h0000};
        cneg[0][l] <= fa[l].neg;
      end
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (adv) begin
        cv[k] <= cv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          cneg[k][l] <= cneg[k-1][l];
          if (!cz[k-1][l][ZW-1]) begin
            cx[k][l] <= cx[k-1][l] - (cy[k-1][l] >>> (k - 1));
            cy[k][l] <= cy[k-1][l] + (cx[k-1][l] >>> (k - 1));
            cz[k][l] <= cz[k-1][l] - $signed(ATAN_TABLE[k-1]);
          end else begin
            cx[k][l] <= cx[k-1][l] + (cy[k-1][l] >>> (k - 1));
            cy[k][l] <= cy[k-1][l] - (cx[k-1][l] >>> (k - 1));
            cz[k][l] <= cz[k-1][l] + $signed(ATAN_TABLE[k-1]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Apply the fold sign: sine and cosine of each lane
  // ---------------------------------------------------------------------
  logic                  t_valid;
  logic signed [W_V-1:0] t_sin [0:2];
  logic signed [W_V-1:0] t_cos [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        t_sin[l] <= cneg[N][l] ? -cy[N][l] : cy[N][l];
        t_cos[l] <= cneg[N][l] ? -cx[N][l] : cx[N][l];
      end
    end
  end

  // ---------------------------------------------------------------------
  // M1: point on the sphere, M2/M3: tilt about x by the view latitude
  // ---------------------------------------------------------------------
  logic                  m1_valid;
  logic signed [W_V-1:0] m1_px, m1_py, m1_pz, m1_sr, m1_cr;
  logic signed [W_S-1:0] prod_px, prod_pz;

  assign prod_px = t_sin[0] * t_cos[1];
  assign prod_pz = t_cos[0] * t_cos[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_px <= prod_px[FB +: W_V];
      m1_pz <= prod_pz[FB +: W_V];
      m1_py <= t_sin[1];
      m1_sr <= t_sin[2];
      m1_cr <= t_cos[2];
    end
  end

  logic                  m2_valid;
  logic signed [W_V-1:0] m2_px;
  logic signed [W_V-1:0] m2_p [0:3];
  logic signed [W_S-1:0] prod_t [0:3];

  assign prod_t[0] = m1_cr * m1_py;
  assign prod_t[1] = m1_sr * m1_pz;
  assign prod_t[2] = m1_cr * m1_pz;
  assign prod_t[3] = m1_sr * m1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (adv) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_px <= m1_px;
      for (int i = 0; i < 4; i++) begin
        m2_p[i] <= prod_t[i][FB +: W_V];
      end
    end
  end

  logic                  m3_valid;
  logic signed [W_V-1:0] m3_px, m3_ty, m3_tz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (adv) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_px <= m2_px;
      m3_ty <= m2_p[0] + m2_p[1];
      m3_tz <= m2_p[2] - m2_p[3];
    end
  end

  // ---------------------------------------------------------------------
  // M4: limb test and squares for the renormalizing length
  // ---------------------------------------------------------------------
  logic                  m4_valid;
  logic [W_S-1:0]        m4_sqx, m4_sqy;
  vec_t                  m4_vec;
  logic signed [W_S-1:0] sq_px, sq_py;

  assign sq_px = m3_px * m3_px;
  assign sq_py = m3_ty * m3_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else if (adv) begin
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_sqx       <= sq_px;
      m4_sqy       <= sq_py;
      m4_vec.px    <= m3_px;
      m4_vec.py    <= m3_ty;
      m4_vec.pz    <= m3_tz;
      m4_vec.clamp <= (m3_tz < LIMIT_V);
    end
  end

  // ---------------------------------------------------------------------
  // Square root: one result bit per stage
  // ---------------------------------------------------------------------
  logic           sq_valid [0:R_SQ];
  logic [W_S-1:0] sq_v     [0:R_SQ];
  logic [W_S-1:0] sq_r     [0:R_SQ];
  vec_t           sq_d     [0:R_SQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_v[0] <= m4_sqx + m4_sqy;
      sq_r[0] <= '0;
      sq_d[0] <= m4_vec;
    end
  end

  for (genvar j = 0; j < R_SQ; j++) begin : g_sqrt
    localparam logic [W_S-1:0] BIT = W_S'(1) << (2 * (R_SQ - 1 - j));
    logic [W_S-1:0] trial;
    assign trial = sq_r[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[j+1] <= sq_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_d[j+1] <= sq_d[j];
        if (sq_v[j] >= trial) begin
          sq_v[j+1] <= sq_v[j] - trial;
          sq_r[j+1] <= (sq_r[j] >> 1) + BIT;
        end else begin
          sq_v[j+1] <= sq_v[j];
          sq_r[j+1] <= sq_r[j] >> 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Renormalizing divide of x and y by the length, one quotient bit a stage
  // ---------------------------------------------------------------------
  logic            rd_valid [0:QR];
  logic [W_RD-1:0] rd_rem   [0:QR][0:1];
  logic [QR-1:0]   rd_q     [0:QR][0:1];
  logic [1:0]      rd_neg   [0:QR];
  logic [W_V-1:0]  rd_len   [0:QR];
  vec_t            rd_d     [0:QR];
  logic [W_V-1:0]  mag_x, mag_y;

  assign mag_x = sq_d[R_SQ].px[W_V-1] ? -sq_d[R_SQ].px : sq_d[R_SQ].px;
  assign mag_y = sq_d[R_SQ].py[W_V-1] ? -sq_d[R_SQ].py : sq_d[R_SQ].py;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid[0] <= 1'b0;
    end else if (adv) begin
      rd_valid[0] <= sq_valid[R_SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_rem[0][0] <= {1'b0, mag_x, {FB{1'b0}}};
      rd_rem[0][1] <= {1'b0, mag_y, {FB{1'b0}}};
      rd_q[0][0]   <= '0;
      rd_q[0][1]   <= '0;
      rd_neg[0]    <= {sq_d[R_SQ].py[W_V-1], sq_d[R_SQ].px[W_V-1]};
      rd_len[0]    <= sq_r[R_SQ][W_V-1:0];
      rd_d[0]      <= sq_d[R_SQ];
    end
  end

  for (genvar k = 0; k < QR; k++) begin : g_rdiv
    logic [W_RD-1:0] dsh;
    logic [1:0]      hit;
    assign dsh = W_RD'(rd_len[k]) << (QR - 1 - k);
    assign hit = {rd_rem[k][1] >= dsh, rd_rem[k][0] >= dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        rd_valid[k+1] <= 1'b0;
      end else if (adv) begin
        rd_valid[k+1] <= rd_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_neg[k+1] <= rd_neg[k];
        rd_len[k+1] <= rd_len[k];
        rd_d[k+1]   <= rd_d[k];
        for (int l = 0; l < 2; l++) begin
          rd_rem[k+1][l] <= hit[l] ? rd_rem[k][l] - dsh : rd_rem[k][l];
          rd_q[k+1][l]   <= {rd_q[k][l][QR-2:0], hit[l]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // R1: pick renormalized x,y and the clamped depth for limb points
  // ---------------------------------------------------------------------
  logic                  r1_valid;
  logic signed [W_V-1:0] r1_vx, r1_vy, r1_vz;
  logic                  r1_clamp;
  logic signed [W_V-1:0] qmag_x, qmag_y;
  logic                  use_norm;

  assign qmag_x   = {{(W_V - QR){1'b0}}, rd_q[QR][0]};
  assign qmag_y   = {{(W_V - QR){1'b0}}, rd_q[QR][1]};
  assign use_norm = rd_d[QR].clamp && (rd_len[QR] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (adv) begin
      r1_valid <= rd_valid[QR];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_vx    <= use_norm ? (rd_neg[QR][0] ? -qmag_x : qmag_x) : rd_d[QR].px;
      r1_vy    <= use_norm ? (rd_neg[QR][1] ? -qmag_y : qmag_y) : rd_d[QR].py;
      r1_vz    <= rd_d[QR].clamp ? LIMIT_V : rd_d[QR].pz;
      r1_clamp <= rd_d[QR].clamp;
    end
  end

  // ---------------------------------------------------------------------
  // R2: depth against the camera and the scaled numerators
  // ---------------------------------------------------------------------
  logic                   r2_valid;
  logic signed [W_ZD-1:0] r2_depth;
  logic signed [W_N-1:0]  r2_num [0:1];
  logic                   r2_clamp;
  logic signed [W_ZD-1:0] cam_shift;
  logic signed [W_N-1:0]  num_x, num_y;

  assign cam_shift = {{(W_ZD - 17){camera_offset[16]}}, camera_offset} <<< (FB - 8);
  assign num_x     = r1_vx * $signed({1'b0, hf});
  assign num_y     = r1_vy * $signed({1'b0, hf});

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (adv) begin
      r2_valid <= r1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_depth  <= {{(W_ZD - W_V){r1_vz[W_V-1]}}, r1_vz} - cam_shift;
      r2_num[0] <= num_x;
      r2_num[1] <= num_y;
      r2_clamp  <= r1_clamp;
    end
  end

  // ---------------------------------------------------------------------
  // P0: magnitudes, signs and divisor (depth * 256)
  // ---------------------------------------------------------------------
  logic            p0_valid;
  logic [W_N-1:0]  p0_mag [0:1];
  logic [1:0]      p0_neg;
  logic [W_DV-1:0] p0_dv;
  logic            p0_den_ok;
  logic            p0_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (adv) begin
      p0_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        p0_mag[l] <= r2_num[l][W_N-1] ? -r2_num[l] : r2_num[l];
        p0_neg[l] <= r2_num[l][W_N-1];
      end
      p0_dv     <= {r2_depth[W_ZD-2:0], 8'h00};
      p0_den_ok <= (r2_depth > 0);
      p0_clamp  <= r2_clamp;
    end
  end

  // ---------------------------------------------------------------------
  // Projection divide: overflow test, then one quotient bit a stage
  // ---------------------------------------------------------------------
  logic            pd_valid [0:QB];
  logic [W_PR-1:0] pd_rem   [0:QB][0:1];
  logic [QB-1:0]   pd_q     [0:QB][0:1];
  logic [W_DV-1:0] pd_dv    [0:QB];
  proj_ctl_t       pd_ctl   [0:QB];
  logic [W_PR-1:0] dv_top;

  assign dv_top = W_PR'(p0_dv) << QB;

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_valid[0] <= 1'b0;
    end else if (adv) begin
      pd_valid[0] <= p0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        pd_rem[0][l]     <= W_PR'(p0_mag[l]);
        pd_q[0][l]       <= '0;
        pd_ctl[0].ovf[l] <= (W_PR'(p0_mag[l]) >= dv_top);
      end
      pd_dv[0]         <= p0_dv;
      pd_ctl[0].neg    <= p0_neg;
      pd_ctl[0].den_ok <= p0_den_ok;
      pd_ctl[0].clamp  <= p0_clamp;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_pdiv
    logic [W_PR-1:0] dsh;
    logic [1:0]      hit;
    assign dsh = W_PR'(pd_dv[k]) << (QB - 1 - k);
    assign hit = {pd_rem[k][1] >= dsh, pd_rem[k][0] >= dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        pd_valid[k+1] <= 1'b0;
      end else if (adv) begin
        pd_valid[k+1] <= pd_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pd_dv[k+1]  <= pd_dv[k];
        pd_ctl[k+1] <= pd_ctl[k];
        for (int l = 0; l < 2; l++) begin
          pd_rem[k+1][l] <= hit[l] ? pd_rem[k][l] - dsh : pd_rem[k][l];
          pd_q[k+1][l]   <= {pd_q[k][l][QB-2:0], hit[l]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final stage: sign, center offset, saturate, and the result register
  // ---------------------------------------------------------------------
  logic signed [W_Q-1:0]   fin_q   [0:1];
  logic signed [W_Q-1:0]   fin_c   [0:1];
  logic signed [W_Q-1:0]   fin_sum [0:1];
  logic signed [OUT_W-1:0] fin_val [0:1];
  logic [1:0]              fin_sat;

  assign fin_c[0] = {{(W_Q - 16){1'b0}}, display_width, 3'b000};
  assign fin_c[1] = {{(W_Q - 16){1'b0}}, display_height, 3'b000};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_q[l]   = pd_ctl[QB].neg[l] ? -$signed({2'b00, pd_q[QB][l]})
                                     : $signed({2'b00, pd_q[QB][l]});
      fin_sum[l] = fin_q[l] + fin_c[l];
      fin_sat[l] = 1'b1;
      if (!pd_ctl[QB].den_ok || pd_ctl[QB].ovf[l]) begin
        fin_val[l] = pd_ctl[QB].neg[l] ? OUT_MIN : OUT_MAX;
      end else if (fin_sum[l] > OUT_MAX) begin
        fin_val[l] = OUT_MAX;
      end else if (fin_sum[l] < OUT_MIN) begin
        fin_val[l] = OUT_MIN;
      end else begin
        fin_val[l] = fin_sum[l][OUT_W-1:0];
        fin_sat[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_valid <= 1'b0;
    end else if (adv) begin
      screen_valid <= pd_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      screen_x     <= fin_val[0];
      screen_y     <= fin_val[1];
      limb_clamped <= pd_ctl[QB].clamp;
      saturated    <= |fin_sat;
    end
  end

endmodule

### rtl/core/llsp_checker.sv
// Port-level checks for the globe point projection top level.
// Bound to lat_lon_to_screen_projection; no package needed.
module llsp_assertions (
  input logic               clk,
  input logic               rst,
  input logic               point_valid,
  input logic               point_stall,
  input logic               screen_valid,
  input logic               screen_stall,
  input logic signed [19:0] screen_x,
  input logic signed [19:0] screen_y,
  input logic               limb_clamped,
  input logic               saturated
);

  // Hold a stalled result.
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    screen_valid && screen_stall |=> screen_valid)
    else $error("result dropped while stalled");

  a_hold_payload : assert property (@(posedge clk) disable iff (rst)
    screen_valid && screen_stall |=> $stable(screen_x) && $stable(screen_y)
      && $stable(limb_clamped) && $stable(saturated))
    else $error("stalled result changed");

  // Requests are refused only while the result register is blocked.
  a_stall_source : assert property (@(posedge clk) disable iff (rst)
    point_stall |-> screen_valid && screen_stall)
    else $error("request stalled without downstream backpressure");

  // Reset drops everything in flight.
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !screen_valid)
    else $error("result valid right after reset");

endmodule

bind lat_lon_to_screen_projection llsp_assertions u_llsp_assertions (.*);
